/* rtl/ssi_pkg.sv */
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared widths, register indexes and constants for the stepper slot indexer.
// ----------------------------------------------------------------------------
package ssi_pkg;

   localparam int unsigned BUTTONS_W  = 3;
   localparam int unsigned COILS_W    = 4;
   localparam int unsigned SLOT_W     = 3;
   localparam int unsigned MODE_W     = 3;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam int unsigned TICK_W     = 8;
   localparam int unsigned STEP_W     = 10;
   localparam int unsigned DEB_W      = 4;
   localparam int unsigned HOMING_W   = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_TICKS     = 3'd0,
      CSR_STEPS_PER_SLOT = 3'd1,
      CSR_SLOT_COUNT     = 3'd2,
      CSR_DEBOUNCE_TICKS = 3'd3,
      CSR_HOMING_LIMIT   = 3'd4
   } csr_idx_type;

   localparam logic [TICK_W-1:0]   STEP_TICKS_RST     = 8'd10;
   localparam logic [STEP_W-1:0]   STEPS_PER_SLOT_RST = 10'd160;
   localparam logic [SLOT_W-1:0]   SLOT_COUNT_RST     = 3'd6;
   localparam logic [DEB_W-1:0]    DEBOUNCE_TICKS_RST = 4'd2;
   localparam logic [HOMING_W-1:0] HOMING_LIMIT_RST   = 16'd32766;

   localparam logic [COILS_W-1:0]   PATTERN_START = 4'b0011;
   localparam logic [STEP_W-1:0]    SLOT_FIRST_STEP = 10'd2;
   localparam logic [BUTTONS_W-1:0] BUTTONS_NONE = 3'b111;
   localparam logic [SLOT_W-1:0]    SLOT_FIRST = 3'd1;

endpackage

/* rtl/ssi_if.sv */
// ----------------------------------------------------------------------------
// ssi_if
// Valid/ready channels of the stepper slot indexer: tick input, result
// output and register write port.
// ----------------------------------------------------------------------------
interface ssi_req_if;
   logic                           valid;
   logic                           ready;
   logic [ssi_pkg::BUTTONS_W-1:0]  buttons_n;
   logic                           home_n;

   modport source (output valid, output buttons_n, output home_n, input ready);
   modport sink   (input valid, input buttons_n, input home_n, output ready);
endinterface

interface ssi_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ssi_pkg::COILS_W-1:0]  coils;
   logic [ssi_pkg::SLOT_W-1:0]   position;
   logic [ssi_pkg::MODE_W-1:0]   mode;

   modport source (output valid, output coils, output position, output mode,
                   input ready);
   modport sink   (input valid, input coils, input position, input mode,
                   output ready);
endinterface

interface ssi_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ssi_pkg::CSR_IDX_W-1:0]   index;
   logic [ssi_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/stepper_slot_indexer_top.sv */
// ----------------------------------------------------------------------------
// stepper_slot_indexer_top
// Homes a stepper, debounces slot buttons and indexes the motor slot by slot.
// ----------------------------------------------------------------------------
// Path: a tick taken from req_ch goes to the input register, then its result
//   goes to the result register, from which it leaves on rsp_ch.
// Throughput: one tick per cycle while rsp_ch is ready; the input register
//   refills while a result waits in the result register.
// Reset: synchronous; state returns to homing at slot 1 with coils 0011 and
//   the registers take their default values.
module stepper_slot_indexer_top (
   input  logic        clock,
   input  logic        reset,
   ssi_req_if.sink     req_ch,
   ssi_rsp_if.source   rsp_ch,
   ssi_csr_if.sink     csr_ch
);

   typedef enum logic [ssi_pkg::MODE_W-1:0] {
      MODE_HOMING   = 3'd0,
      MODE_IDLE     = 3'd1,
      MODE_PRESS    = 3'd2,
      MODE_WAIT_REL = 3'd3,
      MODE_RELEASE  = 3'd4,
      MODE_MOVING   = 3'd5
   } mode_type;

   // configuration
   logic [ssi_pkg::TICK_W-1:0]   step_ticks_ff;
   logic [ssi_pkg::STEP_W-1:0]   steps_per_slot_ff;
   logic [ssi_pkg::SLOT_W-1:0]   slot_count_ff;
   logic [ssi_pkg::DEB_W-1:0]    debounce_ticks_ff;
   logic [ssi_pkg::HOMING_W-1:0] homing_limit_ff;

   // input register
   logic                           s1_valid_ff;
   logic [ssi_pkg::BUTTONS_W-1:0]  s1_buttons_ff;
   logic                           s1_home_n_ff;
   logic                           s1_adv;

   // block state
   mode_type                       mode_ff, mode_in;
   logic [ssi_pkg::SLOT_W-1:0]     pos_ff, pos_in;
   logic [ssi_pkg::SLOT_W-1:0]     target_ff, target_in;
   logic [ssi_pkg::COILS_W-1:0]    pat_ff, pat_in;
   logic [ssi_pkg::STEP_W-1:0]     sis_ff, sis_in;
   logic [ssi_pkg::TICK_W-1:0]     tick_ff, tick_in;
   logic [ssi_pkg::HOMING_W-1:0]   hsteps_ff, hsteps_in;
   logic [ssi_pkg::SLOT_W-1:0]     code_ff, code_in;

   // result register
   logic                           out_valid_ff;
   logic [ssi_pkg::COILS_W-1:0]    out_coils_ff;
   logic [ssi_pkg::SLOT_W-1:0]     out_pos_ff;
   logic [ssi_pkg::MODE_W-1:0]     out_mode_ff;

   // step logic
   logic                           at_home;
   logic                           pressed;
   logic [ssi_pkg::TICK_W-1:0]     tick_inc;
   logic [ssi_pkg::TICK_W-1:0]     tick_adv;
   logic                           deb_done;
   logic [ssi_pkg::SLOT_W-1:0]     code_now;
   logic                           code_bad;
   logic                           slot_end;
   logic [ssi_pkg::SLOT_W:0]       pos_inc;
   logic [ssi_pkg::SLOT_W-1:0]     pos_next;
   logic [ssi_pkg::STEP_W-1:0]     sis_base;
   logic [ssi_pkg::COILS_W-1:0]    pat_base;

   assign s1_adv       = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || !out_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.coils    = out_coils_ff;
   assign rsp_ch.position = out_pos_ff;
   assign rsp_ch.mode     = out_mode_ff;

   assign at_home  = !s1_home_n_ff;
   assign pressed  = s1_buttons_ff != ssi_pkg::BUTTONS_NONE;
   assign tick_inc = tick_ff + 8'd1;
   assign tick_adv = (tick_inc >= step_ticks_ff) ? '0 : tick_inc;
   assign deb_done = tick_inc >= {4'd0, debounce_ticks_ff};
   assign code_now = ~s1_buttons_ff;
   assign code_bad = (code_ff == 3'd0) || (code_ff == 3'd7) ||
                     (code_ff > slot_count_ff) || (code_ff == pos_ff);

   assign slot_end = sis_ff >= steps_per_slot_ff;
   assign pos_inc  = {1'b0, pos_ff} + 4'd1;
   assign pos_next = (at_home || pos_inc > {1'b0, slot_count_ff}) ?
                     ssi_pkg::SLOT_FIRST : pos_inc[ssi_pkg::SLOT_W-1:0];
   assign sis_base = slot_end ? ssi_pkg::SLOT_FIRST_STEP : sis_ff;
   assign pat_base = slot_end ? ssi_pkg::PATTERN_START : pat_ff;

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      target_in = target_ff;
      pat_in    = pat_ff;
      sis_in    = sis_ff;
      tick_in   = tick_ff;
      hsteps_in = hsteps_ff;
      code_in   = code_ff;
      unique case (mode_ff)
         MODE_HOMING: begin
            if (tick_ff == '0 && (at_home || hsteps_ff >= homing_limit_ff)) begin
               mode_in = MODE_IDLE;
            end else begin
               if (tick_ff == '0) begin
                  pat_in    = {pat_ff[2:0], pat_ff[3]};
                  hsteps_in = hsteps_ff + 16'd1;
               end
               tick_in = tick_adv;
            end
         end
         MODE_IDLE: begin
            if (pressed) begin
               mode_in = MODE_PRESS;
               tick_in = '0;
            end
         end
         MODE_PRESS: begin
            tick_in = tick_inc;
            if (deb_done) begin
               code_in = code_now;
               mode_in = MODE_WAIT_REL;
               tick_in = '0;
            end
         end
         MODE_WAIT_REL: begin
            if (!pressed) begin
               mode_in = MODE_RELEASE;
               tick_in = '0;
            end
         end
         MODE_RELEASE: begin
            tick_in = tick_inc;
            if (deb_done) begin
               tick_in = '0;
               if (code_bad) begin
                  mode_in = MODE_IDLE;
               end else begin
                  target_in = code_ff;
                  mode_in   = MODE_MOVING;
                  pat_in    = ssi_pkg::PATTERN_START;
                  sis_in    = ssi_pkg::SLOT_FIRST_STEP;
               end
            end
         end
         MODE_MOVING: begin
            if (tick_ff == '0 && slot_end && pos_next == target_ff) begin
               // target reached: stop with the timer frozen
               pos_in  = pos_next;
               mode_in = MODE_IDLE;
            end else begin
               if (tick_ff == '0) begin
                  if (slot_end) begin
                     pos_in = pos_next;
                  end
                  pat_in = pat_base;
                  sis_in = sis_base;
                  if (sis_base < steps_per_slot_ff) begin
                     pat_in = {pat_base[2:0], pat_base[3]};
                     sis_in = sis_base + 10'd1;
                  end
               end
               tick_in = tick_adv;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ticks_ff     <= ssi_pkg::STEP_TICKS_RST;
         steps_per_slot_ff <= ssi_pkg::STEPS_PER_SLOT_RST;
         slot_count_ff     <= ssi_pkg::SLOT_COUNT_RST;
         debounce_ticks_ff <= ssi_pkg::DEBOUNCE_TICKS_RST;
         homing_limit_ff   <= ssi_pkg::HOMING_LIMIT_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            ssi_pkg::CSR_STEP_TICKS:     step_ticks_ff <= csr_ch.data[7:0];
            ssi_pkg::CSR_STEPS_PER_SLOT: steps_per_slot_ff <= csr_ch.data[9:0];
            ssi_pkg::CSR_SLOT_COUNT:     slot_count_ff <= csr_ch.data[2:0];
            ssi_pkg::CSR_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_ch.data[3:0];
            ssi_pkg::CSR_HOMING_LIMIT:   homing_limit_ff <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
      if (req_ch.valid && req_ch.ready) begin
         s1_buttons_ff <= req_ch.buttons_n;
         s1_home_n_ff  <= req_ch.home_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_HOMING;
         pos_ff    <= ssi_pkg::SLOT_FIRST;
         target_ff <= ssi_pkg::SLOT_FIRST;
         pat_ff    <= ssi_pkg::PATTERN_START;
         sis_ff    <= '0;
         tick_ff   <= '0;
         hsteps_ff <= '0;
         code_ff   <= '0;
      end else if (s1_adv) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         target_ff <= target_in;
         pat_ff    <= pat_in;
         sis_ff    <= sis_in;
         tick_ff   <= tick_in;
         hsteps_ff <= hsteps_in;
         code_ff   <= code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (s1_adv) begin
         out_coils_ff <= pat_in;
         out_pos_ff   <= pos_in;
         out_mode_ff  <= mode_in;
      end
   end

   a_two_coils: assert property (@(posedge clock) disable iff (reset)
      $countones(pat_ff) == 2)
      else $error("coil pattern lost its two-coil form");

   a_move_has_target: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_MOVING |-> target_ff != pos_ff)
      else $error("moving while already at target slot");

   a_homing_exit: assert property (@(posedge clock) disable iff (reset)
      s1_adv && mode_ff == MODE_HOMING && mode_in != MODE_HOMING |->
      mode_in == MODE_IDLE)
      else $error("homing left to a mode other than idle");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> s1_valid_ff)
      else $error("accepted tick did not reach the input register");

   a_result_position: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_pos_ff != 3'd0)
      else $error("result shows slot zero");

endmodule

/* dv/slot_indexer_check.sv */
// ----------------------------------------------------------------------------
// slot_indexer_check
// Watches the tick, result and register channels of the stepper slot indexer.
// Each accepted tick is run through a cycle-free copy of the indexer state
// machine. Each result transaction is compared field by field against the
// oldest predicted coil/position/mode triple.
// ----------------------------------------------------------------------------
module slot_indexer_check (
   input  logic clock,
   input  logic reset,
   ssi_req_if   req,
   ssi_rsp_if   rsp,
   ssi_csr_if   csr,
   output int   fail_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [ssi_pkg::MODE_W-1:0] {
      MODE_HOMING       = 3'd0,
      MODE_IDLE         = 3'd1,
      MODE_PRESS        = 3'd2,
      MODE_WAIT_RELEASE = 3'd3,
      MODE_RELEASE      = 3'd4,
      MODE_MOVING       = 3'd5
   } run_mode_type;

   typedef struct packed {
      logic [ssi_pkg::COILS_W-1:0] coils;
      logic [ssi_pkg::SLOT_W-1:0]  position;
      logic [ssi_pkg::MODE_W-1:0]  mode;
   } tick_output_type;

   // All buttons held gives this code; it never selects a slot.
   localparam logic [ssi_pkg::BUTTONS_W-1:0] CODE_ALL_BUTTONS = 3'b111;

   logic [ssi_pkg::TICK_W-1:0]   cfg_step_ticks;
   logic [ssi_pkg::STEP_W-1:0]   cfg_steps_per_slot;
   logic [ssi_pkg::SLOT_W-1:0]   cfg_slot_count;
   logic [ssi_pkg::DEB_W-1:0]    cfg_debounce;
   logic [ssi_pkg::HOMING_W-1:0] cfg_homing_limit;

   run_mode_type                   run_mode;
   logic [ssi_pkg::SLOT_W-1:0]     position;
   logic [ssi_pkg::SLOT_W-1:0]     target;
   logic [ssi_pkg::COILS_W-1:0]    coils;
   logic [ssi_pkg::STEP_W-1:0]     slot_step;
   logic [ssi_pkg::TICK_W-1:0]     timer;
   logic [ssi_pkg::HOMING_W-1:0]   homing_steps;
   logic [ssi_pkg::BUTTONS_W-1:0]  latched;

   tick_output_type tick_outputs_q[$];

   function automatic logic [ssi_pkg::TICK_W-1:0] next_timer(
      input logic [ssi_pkg::TICK_W-1:0] t);
      logic [ssi_pkg::TICK_W-1:0] n;
      n = t + 8'd1;
      return (n >= cfg_step_ticks) ? '0 : n;
   endfunction

   task automatic reset_indexer();
      cfg_step_ticks     = ssi_pkg::STEP_TICKS_RST;
      cfg_steps_per_slot = ssi_pkg::STEPS_PER_SLOT_RST;
      cfg_slot_count     = ssi_pkg::SLOT_COUNT_RST;
      cfg_debounce       = ssi_pkg::DEBOUNCE_TICKS_RST;
      cfg_homing_limit   = ssi_pkg::HOMING_LIMIT_RST;
      run_mode     = MODE_HOMING;
      position     = ssi_pkg::SLOT_FIRST;
      target       = ssi_pkg::SLOT_FIRST;
      coils        = ssi_pkg::PATTERN_START;
      slot_step    = '0;
      timer        = '0;
      homing_steps = '0;
      latched      = '0;
   endtask

   task automatic write_register(input logic [ssi_pkg::CSR_IDX_W-1:0] index,
                                 input logic [ssi_pkg::CSR_DATA_W-1:0] data);
      case (ssi_pkg::csr_idx_type'(index))
         ssi_pkg::CSR_STEP_TICKS:     cfg_step_ticks     = data[ssi_pkg::TICK_W-1:0];
         ssi_pkg::CSR_STEPS_PER_SLOT: cfg_steps_per_slot = data[ssi_pkg::STEP_W-1:0];
         ssi_pkg::CSR_SLOT_COUNT:     cfg_slot_count     = data[ssi_pkg::SLOT_W-1:0];
         ssi_pkg::CSR_DEBOUNCE_TICKS: cfg_debounce       = data[ssi_pkg::DEB_W-1:0];
         ssi_pkg::CSR_HOMING_LIMIT:   cfg_homing_limit   = data[ssi_pkg::HOMING_W-1:0];
         default: ;
      endcase
   endtask

   task automatic advance_indexer(input logic [ssi_pkg::BUTTONS_W-1:0] buttons_n,
                                  input logic home_n);
      logic                       pressed;
      logic                       at_home;
      logic                       arrived;
      logic [ssi_pkg::SLOT_W:0]   next_pos;
      tick_output_type            out;
      pressed = (buttons_n != ssi_pkg::BUTTONS_NONE);
      at_home = ~home_n;
      arrived = 1'b0;
      case (run_mode)
         MODE_HOMING: begin
            if (timer == '0 && (at_home || homing_steps >= cfg_homing_limit)) begin
               run_mode = MODE_IDLE;
            end else begin
               if (timer == '0) begin
                  coils        = {coils[ssi_pkg::COILS_W-2:0], coils[ssi_pkg::COILS_W-1]};
                  homing_steps = homing_steps + 16'd1;
               end
               timer = next_timer(timer);
            end
         end
         MODE_IDLE: begin
            if (pressed) begin
               run_mode = MODE_PRESS;
               timer    = '0;
            end
         end
         MODE_PRESS: begin
            timer = timer + 8'd1;
            if (timer >= {4'd0, cfg_debounce}) begin
               latched  = ~buttons_n;
               run_mode = MODE_WAIT_RELEASE;
               timer    = '0;
            end
         end
         MODE_WAIT_RELEASE: begin
            if (!pressed) begin
               run_mode = MODE_RELEASE;
               timer    = '0;
            end
         end
         MODE_RELEASE: begin
            timer = timer + 8'd1;
            if (timer >= {4'd0, cfg_debounce}) begin
               timer = '0;
               if (latched == '0 || latched == CODE_ALL_BUTTONS ||
                   latched > cfg_slot_count || latched == position) begin
                  run_mode = MODE_IDLE;
               end else begin
                  target    = latched;
                  run_mode  = MODE_MOVING;
                  coils     = ssi_pkg::PATTERN_START;
                  slot_step = ssi_pkg::SLOT_FIRST_STEP;
               end
            end
         end
         MODE_MOVING: begin
            if (timer == '0) begin
               if (slot_step >= cfg_steps_per_slot) begin
                  next_pos = {1'b0, position} + 4'd1;
                  // home switch low forces slot one
                  if (at_home || next_pos > {1'b0, cfg_slot_count})
                     next_pos = {1'b0, ssi_pkg::SLOT_FIRST};
                  position = next_pos[ssi_pkg::SLOT_W-1:0];
                  if (position == target) begin
                     run_mode = MODE_IDLE;
                     arrived  = 1'b1;
                  end else begin
                     coils     = ssi_pkg::PATTERN_START;
                     slot_step = ssi_pkg::SLOT_FIRST_STEP;
                  end
               end
               if (!arrived && slot_step < cfg_steps_per_slot) begin
                  coils     = {coils[ssi_pkg::COILS_W-2:0], coils[ssi_pkg::COILS_W-1]};
                  slot_step = slot_step + 10'd1;
               end
            end
            if (!arrived)
               timer = next_timer(timer);
         end
         default: run_mode = MODE_IDLE;
      endcase
      out.coils    = coils;
      out.position = position;
      out.mode     = run_mode;
      tick_outputs_q.push_back(out);
   endtask

   task automatic check_result();
      tick_output_type want;
      if (tick_outputs_q.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: result transaction with no tick pending", $realtime);
      end else begin
         want = tick_outputs_q.pop_front();
         if (rsp.coils !== want.coils || rsp.position !== want.position ||
             rsp.mode !== want.mode) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: coils %b/%b position %0d/%0d mode %0d/%0d (expected/actual)",
                        $realtime, want.coils, rsp.coils, want.position, rsp.position,
                        want.mode, rsp.mode);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_indexer();
         tick_outputs_q.delete();
         fail_count = 0;
      end else begin
         if (csr.valid && csr.ready)
            write_register(csr.index, csr.data);
         if (rsp.valid && rsp.ready)
            check_result();
         if (req.valid && req.ready)
            advance_indexer(req.buttons_n, req.home_n);
      end
      pending_count = tick_outputs_q.size();
   end

endmodule

/* dv/stepper_slot_indexer_top_test.sv */
// ----------------------------------------------------------------------------
// stepper_slot_indexer_top_test
// Drives ticks into the stepper slot indexer: a directed pass over homing,
// slot selection and its corner cases, then random button sequences under
// several register settings and idle patterns. Checking is done by
// slot_indexer_check; this module gives the verdict.
// ----------------------------------------------------------------------------
module stepper_slot_indexer_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset;

   ssi_req_if req_ch();
   ssi_rsp_if rsp_ch();
   ssi_csr_if csr_ch();

   int fail_count;
   int pending_count;

   int send_idle_pct;
   int recv_idle_pct;
   bit hold_off_req;
   bit hold_off_done;
   int ticks_sent;
   int cfg_debounce;

   always #5 clock = ~clock;

   stepper_slot_indexer_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   slot_indexer_check checker_i (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .csr           (csr_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin : result_ready
      rsp_ch.ready  = 1'b0;
      hold_off_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_off_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (48) @(negedge clock);
            hold_off_done = 1'b1;
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Starts and ends at a falling edge; valid stays high for the next call.
   task automatic send_tick(input logic [ssi_pkg::BUTTONS_W-1:0] buttons_n,
                            input logic home_n);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.buttons_n <= buttons_n;
      req_ch.home_n    <= home_n;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      ticks_sent++;
      @(negedge clock);
   endtask

   task automatic csr_write(input ssi_pkg::csr_idx_type index, input int unsigned data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data[ssi_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_config(input int unsigned step_ticks, input int unsigned steps,
                               input int unsigned slots, input int unsigned debounce,
                               input int unsigned homing_limit);
      csr_write(ssi_pkg::CSR_STEP_TICKS, step_ticks);
      csr_write(ssi_pkg::CSR_STEPS_PER_SLOT, steps);
      csr_write(ssi_pkg::CSR_SLOT_COUNT, slots);
      csr_write(ssi_pkg::CSR_DEBOUNCE_TICKS, debounce);
      csr_write(ssi_pkg::CSR_HOMING_LIMIT, homing_limit);
      csr_ch.valid <= 1'b0;
      cfg_debounce = debounce;
   endtask

   // Drop valid and hold until every tick has produced its result.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Press a slot code, release it, then let the motor run.
   task automatic select_slot(input logic [ssi_pkg::BUTTONS_W-1:0] code,
                              input int press_ticks, input int release_ticks,
                              input int run_ticks, input logic home_n);
      repeat (press_ticks)   send_tick(~code, 1'b1);
      repeat (release_ticks) send_tick(ssi_pkg::BUTTONS_NONE, 1'b1);
      repeat (run_ticks)     send_tick(ssi_pkg::BUTTONS_NONE, home_n);
   endtask

   initial begin : stimulus
      int                            block_end;
      int                            guard;
      logic [ssi_pkg::BUTTONS_W-1:0] code;
      logic [ssi_pkg::BUTTONS_W-1:0] noise_buttons;
      logic                          home_level;

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.buttons_n = ssi_pkg::BUTTONS_NONE;
      req_ch.home_n    = 1'b1;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = ssi_pkg::CSR_STEP_TICKS;
      csr_ch.data      = '0;
      send_idle_pct    = 32;
      recv_idle_pct    = 67;
      hold_off_req     = 1'b0;
      ticks_sent       = 0;
      cfg_debounce     = int'(ssi_pkg::DEBOUNCE_TICKS_RST);

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: fast motor, short slots, no debounce
      write_config(1, 2, 6, 0, 2);
      // homing ends on the switch or at the step limit
      repeat (3) send_tick(ssi_pkg::BUTTONS_NONE, 1'($urandom_range(0, 1)));
      select_slot(3'd7, 2, 2, 1, 1'b1);   // all buttons: ignored
      select_slot(3'd3, 2, 2, 3, 1'b1);   // move two slots
      select_slot(3'd3, 2, 2, 0, 1'b1);   // already there
      select_slot(3'd5, 1, 3, 0, 1'b1);   // released before latch: code zero
      select_slot(3'd2, 2, 2, 3, 1'b0);   // home held low pins slot one
      repeat (3) send_tick(ssi_pkg::BUTTONS_NONE, 1'b1);

      for (int blk = 0; blk < 6; blk++) begin
         wait_drained();
         send_idle_pct = (blk < 2) ? 32 : (blk < 4) ? 67 : 0;
         recv_idle_pct = (blk < 2) ? 67 : (blk < 4) ? 32 : 0;
         if (blk == 1)
            write_config(255, 2, 7, 15, 65535);
         else if (blk == 3)
            write_config(0, 1023, 1, 0, 0);
         else
            write_config($urandom_range(0, 3), $urandom_range(0, 8), $urandom_range(0, 7),
                         $urandom_range(0, 3), $urandom_range(0, 65535));
         if (blk == 4)
            hold_off_req = 1'b1;
         block_end = ticks_sent + 125;
         while (ticks_sent < block_end) begin
            if ($urandom_range(0, 99) < 75) begin
               code       = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(1, 6))
                                                        : 3'($urandom_range(0, 7));
               home_level = ($urandom_range(0, 5) != 0);
               select_slot(code, $urandom_range(1, cfg_debounce + 3),
                           $urandom_range(1, cfg_debounce + 3), $urandom_range(0, 24),
                           home_level);
            end else begin
               repeat ($urandom_range(1, 8)) begin
                  noise_buttons = 3'($urandom_range(0, 7));
                  send_tick(noise_buttons, $urandom_range(0, 7) != 0);
               end
            end
         end
      end

      req_ch.valid <= 1'b0;
      guard = 0;
      while (pending_count != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (8) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* filelist.f */
rtl/ssi_pkg.sv
rtl/ssi_if.sv
rtl/stepper_slot_indexer_top.sv
dv/slot_indexer_check.sv
dv/stepper_slot_indexer_top_test.sv
